// File: hw/rtl/sm3_pkg.sv
// SM3 engine shared types, constants and round functions.
package sm3_pkg;

    localparam logic [31:0] T_LOW    = 32'h79CC4519;
    localparam logic [31:0] T_HIGH   = 32'h7A879D8A;
    localparam logic [7:0]  PAD_BYTE = 8'h80;
    localparam int unsigned ROUNDS   = 64;
    localparam int unsigned BLK_WORDS = 16;

    typedef logic [31:0] word_t;
    typedef word_t [7:0] state_t;

    localparam state_t INIT_VALUE = '{
        32'hB0FB0E4E, 32'hE38DEE4D, 32'h163138AA, 32'hA96F30BC,
        32'hDA8A0600, 32'h172442D7, 32'h4914B2B9, 32'h7380166F
    };

    typedef enum logic [2:0] {
        ST_COLLECT,
        ST_PAD,
        ST_LEN_HI,
        ST_LEN_LO,
        ST_COMPRESS,
        ST_OUTPUT
    } ctrl_state_t;

    // start pulse to the round unit and done flag back
    typedef struct packed {
        logic start;
        logic done;
        logic busy;
    } round_ctl_t;

    function automatic word_t rotl(input word_t x, input logic [4:0] n);
        logic [63:0] d;
        d = {x, x} << n;
        return d[63:32];
    endfunction

    function automatic word_t perm0(input word_t x);
        return x ^ rotl(x, 5'd9) ^ rotl(x, 5'd17);
    endfunction

    function automatic word_t perm1(input word_t x);
        return x ^ rotl(x, 5'd15) ^ rotl(x, 5'd23);
    endfunction

endpackage

// File: hw/rtl/sm3_stream_if.sv
// Valid/ready channel carrying one word of payload.
interface sm3_stream_if #(
    parameter int unsigned PAYLOAD_W = 36
);
    logic                 valid;
    logic                 ready;
    logic [PAYLOAD_W-1:0] payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

// File: hw/rtl/sm3_round.sv
// SM3 compression unit: one round per cycle over a 16-word sliding expansion window.
module sm3_round
    import sm3_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  word_t [15:0]      block,
    input  state_t            cv_in,
    output logic              busy,
    output logic              done,
    output state_t            cv_out
);

    word_t [15:0] win_reg, win_next;
    state_t       r_reg, r_next;
    logic [5:0]   rnd_reg, rnd_next;
    logic         busy_reg, busy_next;
    logic         done_reg, done_next;

    word_t new_w, a12, ss1, ss2, ff, gg, tt1, tt2, t_rot;
    word_t a, b, c, d, e, f, g, h;

    always_comb
    begin
        {h, g, f, e, d, c, b, a} = r_reg;
        // next expansion word W[j+16] from the window W[j..j+15]
        new_w = perm1(win_reg[0] ^ win_reg[7] ^ rotl(win_reg[13], 5'd15))
              ^ rotl(win_reg[3], 5'd7) ^ win_reg[10];
        t_rot = rotl((rnd_reg < 6'd16) ? T_LOW : T_HIGH, rnd_reg[4:0]);
        a12 = rotl(a, 5'd12);
        ss1 = rotl(a12 + e + t_rot, 5'd7);
        ss2 = ss1 ^ a12;
        if (rnd_reg < 6'd16)
        begin
            ff = a ^ b ^ c;
            gg = e ^ f ^ g;
        end
        else
        begin
            ff = (a & b) | (a & c) | (b & c);
            gg = (e & f) | (~e & g);
        end
        tt1 = ff + d + ss2 + (win_reg[0] ^ win_reg[4]);
        tt2 = gg + h + ss1 + win_reg[0];

        win_next  = win_reg;
        r_next    = r_reg;
        rnd_next  = rnd_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            win_next  = block;
            r_next    = cv_in;
            rnd_next  = '0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            win_next = {new_w, win_reg[15:1]};
            r_next   = {g, rotl(f, 5'd19), e, perm0(tt2), c, rotl(b, 5'd9), a, tt1};
            rnd_next = rnd_reg + 6'd1;
            if (rnd_reg == 6'(ROUNDS - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            rnd_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            rnd_reg  <= rnd_next;
        end
    end

    always_ff @(posedge clk)
    begin
        win_reg <= win_next;
        r_reg   <= r_next;
    end

    assign busy   = busy_reg;
    assign done   = done_reg;
    assign cv_out = r_reg;

endmodule

// File: hw/rtl/sm3_hash_engine.sv
// SM3 hash engine top level: word intake, padding sequencer and digest output.
// Accepts one 32-bit message word per cycle while a block fills. The sixteenth
// word of a block starts the shared round unit, which runs 64 rounds at one per
// cycle; intake stalls through the rounds and the feed-forward of each block.
// On the last word the sequencer writes padding and the 64-bit bit length one
// word per cycle, pausing while it compresses once or twice, then presents the
// eight digest words, index 0 first, one per cycle as the sink takes them. The
// IV is reloaded afterward.
module sm3_hash_engine
    import sm3_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    sm3_stream_if.sink   in_ch,
    sm3_stream_if.source out_ch
);

    ctrl_state_t  state_reg, state_next;
    ctrl_state_t  after_reg, after_next;
    word_t [15:0] blk_reg;
    word_t [15:0] blk_view;
    state_t       cv_reg, cv_next;
    logic [60:0]  cnt_reg, cnt_next;
    logic [3:0]   fill_reg, fill_next;
    logic [2:0]   oidx_reg, oidx_next;
    logic         fin_reg, fin_next;

    logic         wr_en;
    logic [3:0]   wr_idx;
    word_t        wr_data;
    round_ctl_t   rc;
    state_t       rnd_cv;

    word_t        in_word;
    logic [2:0]   in_vb;
    logic         in_last;
    logic [2:0]   vb;
    word_t        keep;
    logic [63:0]  bits;
    logic         in_acc;

    assign in_word = in_ch.payload[35:4];
    assign in_vb   = in_ch.payload[3:1];
    assign in_last = in_ch.payload[0];
    assign vb      = (in_vb > 3'd4) ? 3'd4 : in_vb;
    assign in_ch.ready = (state_reg == ST_COLLECT);
    assign in_acc  = in_ch.valid && in_ch.ready;
    assign bits    = {cnt_reg, 3'b000};

    // the word written in the start cycle goes straight to the round unit
    always_comb
    begin
        blk_view = blk_reg;
        if (wr_en)
            blk_view[wr_idx] = wr_data;
    end

    sm3_round u_round (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (rc.start),
        .block  (blk_view),
        .cv_in  (cv_reg),
        .busy   (rc.busy),
        .done   (rc.done),
        .cv_out (rnd_cv)
    );

    always_comb
    begin
        state_next = state_reg;
        after_next = after_reg;
        cv_next    = cv_reg;
        cnt_next   = cnt_reg;
        fill_next  = fill_reg;
        oidx_next  = oidx_reg;
        fin_next   = fin_reg;
        wr_en      = 1'b0;
        wr_idx     = fill_reg;
        wr_data    = '0;
        rc.start   = 1'b0;
        keep       = '0;
        unique case (state_reg)
            ST_COLLECT:
            begin
                if (in_acc)
                begin
                    wr_en = 1'b1;
                    if (!in_last)
                    begin
                        cnt_next   = cnt_reg + 61'd4;
                        wr_data    = in_word;
                        after_next = ST_COLLECT;
                    end
                    else
                    begin
                        cnt_next = cnt_reg + 61'(vb);
                        fin_next = 1'b1;
                        if (vb == 3'd4)
                        begin
                            wr_data    = in_word;
                            after_next = ST_PAD;
                        end
                        else
                        begin
                            keep = ~(32'hFFFFFFFF >> {vb, 3'b000});
                            wr_data = (in_word & keep)
                                    | ({PAD_BYTE, 24'h0} >> {vb, 3'b000});
                            after_next = ST_LEN_HI;
                        end
                    end
                    fill_next = fill_reg + 4'd1;
                    if (fill_reg == 4'(BLK_WORDS - 1))
                    begin
                        rc.start   = 1'b1;
                        state_next = ST_COMPRESS;
                    end
                    else
                        state_next = after_next;
                end
            end
            ST_PAD:
            begin
                wr_en     = 1'b1;
                wr_data   = {PAD_BYTE, 24'h0};
                fill_next = fill_reg + 4'd1;
                after_next = ST_LEN_HI;
                if (fill_reg == 4'(BLK_WORDS - 1))
                begin
                    rc.start   = 1'b1;
                    state_next = ST_COMPRESS;
                end
                else
                    state_next = ST_LEN_HI;
            end
            ST_LEN_HI:
            begin
                // zero fill until the two length words fit in this block
                wr_en     = 1'b1;
                wr_data   = (fill_reg == 4'd14) ? bits[63:32] : '0;
                fill_next = fill_reg + 4'd1;
                if (fill_reg == 4'd14)
                    state_next = ST_LEN_LO;
                else if (fill_reg == 4'(BLK_WORDS - 1))
                begin
                    rc.start   = 1'b1;
                    after_next = ST_LEN_HI;
                    state_next = ST_COMPRESS;
                end
            end
            ST_LEN_LO:
            begin
                wr_en      = 1'b1;
                wr_data    = bits[31:0];
                fill_next  = '0;
                rc.start   = 1'b1;
                after_next = ST_OUTPUT;
                state_next = ST_COMPRESS;
            end
            ST_COMPRESS:
            begin
                if (rc.done)
                begin
                    for (int i = 0; i < 8; i++)
                        cv_next[i] = cv_reg[i] ^ rnd_cv[i];
                    oidx_next  = '0;
                    state_next = after_reg;
                end
            end
            ST_OUTPUT:
            begin
                if (out_ch.ready)
                begin
                    oidx_next = oidx_reg + 3'd1;
                    if (oidx_reg == 3'd7)
                    begin
                        cv_next    = INIT_VALUE;
                        cnt_next   = '0;
                        fill_next  = '0;
                        fin_next   = 1'b0;
                        state_next = ST_COLLECT;
                    end
                end
            end
            default:
                state_next = ST_COLLECT;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_COLLECT;
            after_reg <= ST_COLLECT;
            cv_reg    <= INIT_VALUE;
            cnt_reg   <= '0;
            fill_reg  <= '0;
            oidx_reg  <= '0;
            fin_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            after_reg <= after_next;
            cv_reg    <= cv_next;
            cnt_reg   <= cnt_next;
            fill_reg  <= fill_next;
            oidx_reg  <= oidx_next;
            fin_reg   <= fin_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
            blk_reg[wr_idx] <= wr_data;
    end

    assign out_ch.valid   = (state_reg == ST_OUTPUT);
    assign out_ch.payload = {cv_reg[oidx_reg], oidx_reg, oidx_reg == 3'd7};

    a_idle_round: assert property (@(posedge clk) disable iff (!rst_n)
        rc.busy |-> state_reg == ST_COMPRESS)
        else $error("round unit busy outside compress");
    a_out_final: assert property (@(posedge clk) disable iff (!rst_n)
        out_ch.valid |-> fin_reg)
        else $error("digest shown before last word");
    a_start_full: assert property (@(posedge clk) disable iff (!rst_n)
        rc.start |-> fill_reg == 4'(BLK_WORDS - 1))
        else $error("compress started on partial block");

endmodule
